// ===== rtl/srfr_pkg.sv =====
`timescale 1ns / 1ps

package srfr_pkg;

  localparam int CHANNELS_DEF = 14;

  localparam int BYTE_W   = 8;
  localparam int VALUE_W  = 16;
  localparam int INDEX_W  = 4;
  localparam int OFFSET_W = 5;
  localparam int SUM_W    = 20;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h55;
  localparam logic [BYTE_W-1:0] HOLD_LO     = 8'd4;
  localparam logic [BYTE_W-1:0] HOLD_HI     = 8'd7;

  // Command from the byte parser to the channel walker.
  typedef struct packed {
    logic                 commit;  // 1: frame passed its checksum, emit it
    logic [INDEX_W-1:0]   index;   // channel number for a store
    logic [VALUE_W-1:0]   value;   // channel value for a store
  } cmd_t;

endpackage

// ===== rtl/servo_frame_receiver_unit.sv =====
`timescale 1ns / 1ps

// Servo channel frame receiver.
// Input channel: push a received serial byte on rx_byte while full is low;
// a transfer happens on each clock edge with push high and full low.
// Output channel: while empty is low, channel_index, channel_value and
// last_channel show the oldest decoded channel; pop takes it.
// A frame is a 0x55 header, CHANNELS little-endian 16-bit values and a
// little-endian 16-bit checksum equal to the sum of the values. Only
// frames whose checksum matches produce results: CHANNELS transfers, the
// final one with last_channel set. Bad frames produce nothing.
// Bytes are taken one per cycle while full is low. The parser
// hands each finished channel and the frame's pass mark to the
// walker through a two-entry queue. The walker emits a passing
// frame's channels in order, each after one memory read plus the
// output register load, as long as the receiver keeps popping.
// Channel stores wait in the queue during a walk; once two wait, full
// rises until the walk ends. When the receiver stalls, the walker holds,
// the queue fills, and full stays high until the walk ends.
// Synchronous reset returns the parser to idle outside any frame and
// empties the queue and the output register.
module servo_frame_receiver_unit #(
  parameter int CHANNELS = srfr_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [srfr_pkg::BYTE_W-1:0]  rx_byte,
  output logic                        empty,
  input  logic                        pop,
  output logic [srfr_pkg::INDEX_W-1:0] channel_index,
  output logic [srfr_pkg::VALUE_W-1:0] channel_value,
  output logic                        last_channel
);
  import srfr_pkg::*;

  logic accept;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_full;
  logic cmd_empty;
  logic cmd_pop;
  logic out_valid;

  // A byte may complete a channel or a frame, so hold off input while the queue is full.
  assign full   = cmd_full;
  assign accept = push && !cmd_full;
  assign empty  = !out_valid;

  // Front: parse bytes, track header resync and checksum, emit commands.
  srfr_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // Decouple parser and walker so each side can stall on its own.
  srfr_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  // Back: store channel values, walk them out on a passing frame.
  srfr_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_empty     (cmd_empty),
    .cmd           (cmd_out),
    .cmd_pop       (cmd_pop),
    .out_valid     (out_valid),
    .out_pop       (pop),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last_channel  (last_channel)
  );

endmodule

// ===== rtl/srfr_front.sv =====
`timescale 1ns / 1ps

module srfr_front #(
  parameter int CHANNELS = srfr_pkg::CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [srfr_pkg::BYTE_W-1:0] rx_byte,
  output logic                       cmd_push,
  output srfr_pkg::cmd_t             cmd
);
  import srfr_pkg::*;

  localparam logic [OFFSET_W-1:0] LAST_POS = OFFSET_W'(2 * CHANNELS + 2);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_FRAME,
    MODE_HOLD
  } mode_t;

  mode_t               mode, mode_next;
  logic [OFFSET_W-1:0] offset, offset_next;
  logic [BYTE_W-1:0]   low, low_next;
  logic [SUM_W-1:0]    sum, sum_next;

  logic                do_take;
  logic [OFFSET_W-1:0] pos;
  logic [VALUE_W-1:0]  word;
  logic [OFFSET_W-1:0] half;

  always_comb begin
    mode_next   = mode;
    offset_next = offset;
    low_next    = low;
    sum_next    = sum;
    do_take     = 1'b0;
    pos         = offset;
    cmd_push    = 1'b0;
    cmd         = '0;
    word        = '0;
    half        = '0;

    if (accept) begin
      unique case (mode)
        MODE_HOLD: begin
          mode_next = MODE_FRAME;
          do_take   = 1'b1;
          if (rx_byte >= HOLD_LO && rx_byte <= HOLD_HI) begin
            // keep the held header as channel 0's low byte
            low_next = HEADER_BYTE;
            pos      = OFFSET_W'(2);
          end else begin
            pos = OFFSET_W'(1);
          end
        end
        MODE_FRAME: begin
          if (offset == OFFSET_W'(1) && rx_byte == HEADER_BYTE) begin
            mode_next = MODE_HOLD;
          end else begin
            do_take = 1'b1;
          end
        end
        default: begin
          mode_next = MODE_IDLE;
          if (rx_byte == HEADER_BYTE) begin
            mode_next   = MODE_FRAME;
            offset_next = OFFSET_W'(1);
            sum_next    = '0;
          end
        end
      endcase

      if (do_take) begin
        if (pos >= LAST_POS) begin
          // checksum high byte: compare and close the frame
          mode_next   = MODE_IDLE;
          offset_next = '0;
          sum_next    = '0;
          if (sum == {{(SUM_W - VALUE_W){1'b0}}, rx_byte, low}) begin
            cmd_push   = 1'b1;
            cmd.commit = 1'b1;
          end
        end else begin
          offset_next = pos + OFFSET_W'(1);
          if (pos[0]) begin
            low_next = rx_byte;
          end else begin
            word       = {rx_byte, low_next};
            half       = pos >> 1;
            sum_next   = sum + {{(SUM_W - VALUE_W){1'b0}}, word};
            cmd_push   = 1'b1;
            cmd.commit = 1'b0;
            cmd.index  = INDEX_W'(half - OFFSET_W'(1));
            cmd.value  = word;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      offset <= '0;
      sum    <= '0;
    end else begin
      mode   <= mode_next;
      offset <= offset_next;
      sum    <= sum_next;
    end
    low <= low_next;
  end

endmodule

// ===== rtl/srfr_cmdq.sv =====
`timescale 1ns / 1ps

module srfr_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  srfr_pkg::cmd_t wdata,
  output logic           full,
  input  logic           pop,
  output srfr_pkg::cmd_t rdata,
  output logic           empty
);
  import srfr_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== rtl/srfr_back.sv =====
`timescale 1ns / 1ps

module srfr_back #(
  parameter int CHANNELS = srfr_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_empty,
  input  srfr_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  output logic                        out_valid,
  input  logic                        out_pop,
  output logic [srfr_pkg::INDEX_W-1:0] channel_index,
  output logic [srfr_pkg::VALUE_W-1:0] channel_value,
  output logic                        last_channel
);
  import srfr_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   walk_idx;
  logic [VALUE_W-1:0] chan_mem [CHANNELS];
  logic [VALUE_W-1:0] rd_data;
  logic               slot_free;

  assign cmd_pop   = (state == ST_IDLE) && !cmd_empty;
  assign slot_free = !out_valid || out_pop;

  // channel store: written from store commands, read one entry per walk step
  always_ff @(posedge clk) begin
    if (cmd_pop && !cmd.commit) begin
      chan_mem[cmd.index[IDX_W-1:0]] <= cmd.value;
    end
    rd_data <= chan_mem[walk_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      walk_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      // load a new channel when the slot frees up, else drop the popped one
      if (state == ST_SEND && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_pop && cmd.commit) begin
            walk_idx <= '0;
            state    <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_SEND;
        end
        ST_SEND: begin
          if (slot_free) begin
            channel_index <= INDEX_W'(walk_idx);
            channel_value <= rd_data;
            last_channel  <= (walk_idx == LAST_IDX);
            if (walk_idx == LAST_IDX) begin
              state <= ST_IDLE;
            end else begin
              walk_idx <= walk_idx + IDX_W'(1);
              state    <= ST_READ;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Frame receiver testbench.
// Bytes go in through the push/full side and decoded channels come out
// through the empty/pop side. An in-bench decoder tracks the parser state
// byte by byte and queues the channels that each good frame should
// produce. Every popped channel is checked field by field against the
// oldest queued one.
module tb;
  import srfr_pkg::*;

  localparam int CH               = CHANNELS_DEF;
  localparam int FRAME_LEN        = 2 * CH + 3;
  localparam int PHASES           = 4;
  localparam int RAND_BYTES       = 124;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 64;
  localparam int N_ROWS           = 11;

  // Idle percentages per phase: none, sender only, receiver only, both.
  localparam int SEND_PCT [PHASES] = '{0, 52, 0, 34};
  localparam int RECV_PCT [PHASES] = '{0, 0, 52, 34};

  typedef enum logic [1:0] {RX_IDLE, RX_FRAME, RX_HOLD} rx_state_e;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    logic               last;
  } chan_rec_t;

  // One directed frame: optional noise in front, an optional repeated
  // header, channel fill with an optional override on channel 0, and a
  // checksum corruption mask. Rows marked typed carry their own result.
  typedef struct packed {
    logic [2:0]  n_lead;
    logic [7:0]  lead;
    logic        extra_hdr;
    logic [15:0] fill;
    logic        ch0_en;
    logic [15:0] ch0;
    logic [15:0] sum_xor;
    logic        typed;
    logic [4:0]  typed_n;
  } frame_row_t;

  localparam frame_row_t DIR_ROWS [N_ROWS] = '{
    // idle noise, then an all-zero frame
    '{3'd2, 8'h00, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b1, 5'd14},
    // channel sum lands exactly on 0xFFFF
    '{3'd1, 8'hFF, 1'b0, 16'h1249, 1'b1, 16'h124A, 16'h0000, 1'b1, 5'd14},
    // all channels at max: the sum overflows 16 bits and never matches
    '{3'd0, 8'h00, 1'b0, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 1'b1, 5'd0},
    // checksum off by one bit
    '{3'd1, 8'hAA, 1'b0, 16'h05DC, 1'b0, 16'h0000, 16'h0001, 1'b1, 5'd0},
    // repeated header, next byte outside 4..7: the extra header is dropped
    '{3'd0, 8'h00, 1'b1, 16'h03E8, 1'b0, 16'h0000, 16'h0000, 1'b0, 5'd0},
    // channel 0 low byte equals the header, high byte at both ends of 4..7
    '{3'd0, 8'h00, 1'b0, 16'h05DC, 1'b1, 16'h0455, 16'h0000, 1'b0, 5'd0},
    '{3'd0, 8'h00, 1'b0, 16'h05DC, 1'b1, 16'h0755, 16'h0000, 1'b0, 5'd0},
    // same low byte, high byte just outside 4..7: the frame slips
    '{3'd0, 8'h00, 1'b0, 16'h05DC, 1'b1, 16'h0355, 16'h0000, 1'b0, 5'd0},
    '{3'd1, 8'h00, 1'b0, 16'h05DC, 1'b1, 16'h0855, 16'h0000, 1'b0, 5'd0},
    // repeated header followed by a byte inside 4..7
    '{3'd1, 8'h01, 1'b1, 16'h05DC, 1'b1, 16'h0006, 16'h0000, 1'b0, 5'd0},
    // clean frame to resync
    '{3'd2, 8'h00, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0, 5'd0}
  };

  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  logic [BYTE_W-1:0]   rx_byte;
  logic                empty;
  logic                pop = 1'b0;
  logic [INDEX_W-1:0]  channel_index;
  logic [VALUE_W-1:0]  channel_value;
  logic                last_channel;

  // Decoder state kept in step with the parser.
  rx_state_e           rx_state;
  logic [OFFSET_W-1:0] frame_off;
  logic [BYTE_W-1:0]   frame_buf [FRAME_LEN];
  logic [SUM_W-1:0]    frame_sum;

  chan_rec_t           pending_channels [$];
  chan_rec_t           head_rec;
  logic [BYTE_W-1:0]   stim_q [$];
  logic [VALUE_W-1:0]  chan_vals [CH];
  bit                  use_typed;
  int                  err_count;
  int                  idle_cycles;
  int                  send_idle_pct;
  int                  recv_stall_pct;

  servo_frame_receiver_unit dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .rx_byte       (rx_byte),
    .empty         (empty),
    .pop           (pop),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last_channel  (last_channel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Store one byte of the current frame; on the checksum byte compare the
  // running channel sum and queue the frame's channels if it matches.
  function automatic void store_frame_byte(input logic [BYTE_W-1:0] b);
    logic [VALUE_W-1:0] rx_sum;
    chan_rec_t          rec;
    if (frame_off >= OFFSET_W'(FRAME_LEN - 1)) begin
      rx_sum    = {b, frame_buf[FRAME_LEN-2]};
      rx_state  = RX_IDLE;
      frame_off = '0;
      if (frame_sum == {4'h0, rx_sum}) begin
        for (int i = 0; i < CH; i++) begin
          rec.index = INDEX_W'(i);
          rec.value = {frame_buf[2*i+2], frame_buf[2*i+1]};
          rec.last  = (i == CH - 1);
          if (!use_typed) pending_channels.push_back(rec);
        end
      end
      frame_sum = '0;
    end else begin
      frame_buf[frame_off] = b;
      // Add a channel once its high byte is in.
      if (frame_off >= 2 && !frame_off[0])
        frame_sum = frame_sum + {4'h0, b, frame_buf[frame_off-1]};
      frame_off = frame_off + OFFSET_W'(1);
    end
  endfunction

  // Advance the decoder by one accepted byte.
  function automatic void decode_rx_byte(input logic [BYTE_W-1:0] b);
    case (rx_state)
      RX_HOLD: begin
        rx_state = RX_FRAME;
        // Keep the held header as channel 0's low byte only when the new
        // byte looks like a plausible high byte.
        if (b >= HOLD_LO && b <= HOLD_HI) begin
          frame_buf[1] = HEADER_BYTE;
          frame_off    = OFFSET_W'(2);
        end else begin
          frame_off = OFFSET_W'(1);
        end
        store_frame_byte(b);
      end
      RX_FRAME: begin
        if (frame_off == OFFSET_W'(1) && b == HEADER_BYTE) rx_state = RX_HOLD;
        else store_frame_byte(b);
      end
      default: begin
        // Outside a frame only a header byte matters.
        if (b == HEADER_BYTE) begin
          frame_buf[0] = b;
          frame_off    = OFFSET_W'(1);
          frame_sum    = '0;
          rx_state     = RX_FRAME;
        end
      end
    endcase
  endfunction

  // Append a frame built from chan_vals; sum_xor corrupts the checksum.
  function automatic void build_frame(input logic [15:0] sum_xor);
    logic [SUM_W-1:0]   total;
    logic [VALUE_W-1:0] ck;
    total = '0;
    stim_q.push_back(HEADER_BYTE);
    for (int i = 0; i < CH; i++) begin
      stim_q.push_back(chan_vals[i][7:0]);
      stim_q.push_back(chan_vals[i][15:8]);
      total = total + {4'h0, chan_vals[i]};
    end
    ck = total[15:0] ^ sum_xor;
    stim_q.push_back(ck[7:0]);
    stim_q.push_back(ck[15:8]);
  endfunction

  // Drain stim_q into the block, one transfer per byte. Enter and leave at
  // a falling edge; push stays high between back-to-back bytes.
  task automatic send_bytes();
    while (stim_q.size() != 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        push = 1'b0;
        @(negedge clk);
      end
      push    = 1'b1;
      rx_byte = stim_q.pop_front();
      @(posedge clk);
      while (full) @(posedge clk);
      decode_rx_byte(rx_byte);
      @(negedge clk);
    end
  endtask

  // Receiver side: stall at random at the current phase's rate.
  always @(negedge clk) begin
    pop = ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each popped channel against the oldest queued one, and watch for
  // a stretch with no transfer on either side.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (pop && !empty) begin
        if (pending_channels.size() == 0) begin
          $error("channel_index: expected none, actual %0d (channel_value %0h)",
                 channel_index, channel_value);
          err_count++;
        end else begin
          head_rec = pending_channels.pop_front();
          if (channel_index !== head_rec.index) begin
            $error("channel_index: expected %0d, actual %0d", head_rec.index, channel_index);
            err_count++;
          end
          if (channel_value !== head_rec.value) begin
            $error("channel_value: expected %0h, actual %0h", head_rec.value, channel_value);
            err_count++;
          end
          if (last_channel !== head_rec.last) begin
            $error("last_channel: expected %0b, actual %0b", head_rec.last, last_channel);
            err_count++;
          end
        end
      end
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    frame_row_t row;
    int         ph;
    int         kind;
    int         n;
    int         phase_bytes;

    rst            = 1'b1;
    push           = 1'b0;
    rx_byte        = '0;
    use_typed      = 1'b0;
    err_count      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rx_state       = RX_IDLE;
    frame_off      = '0;
    frame_sum      = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed frames, no idling on either side.
    for (int r = 0; r < N_ROWS; r++) begin
      row = DIR_ROWS[r];
      repeat (row.n_lead) stim_q.push_back(row.lead);
      if (row.extra_hdr) stim_q.push_back(HEADER_BYTE);
      for (int i = 0; i < CH; i++) chan_vals[i] = row.fill;
      if (row.ch0_en) chan_vals[0] = row.ch0;
      build_frame(row.sum_xor);
      // Typed rows queue their own channels; the decoder still tracks state.
      use_typed = row.typed;
      if (row.typed) begin
        for (int i = 0; i < row.typed_n; i++)
          pending_channels.push_back('{INDEX_W'(i), chan_vals[i], (i == CH - 1)});
      end
      send_bytes();
      use_typed = 1'b0;
    end

    // Random traffic: mostly well-formed frames with servo-like values,
    // plus corrupted, overflowing, truncated frames and line noise.
    for (ph = 0; ph < PHASES; ph++) begin
      send_idle_pct  = SEND_PCT[ph];
      recv_stall_pct = RECV_PCT[ph];
      phase_bytes    = 0;
      while (phase_bytes < RAND_BYTES / PHASES) begin
        kind = $urandom_range(99);
        if (kind < 70) begin
          for (int i = 0; i < CH; i++) begin
            if ($urandom_range(4) == 0) chan_vals[i] = 16'($urandom_range(4681, 0));
            else chan_vals[i] = 16'($urandom_range(2000, 1000));
          end
          // Header-like low byte on channel 0 drives the hold path.
          if ($urandom_range(9) == 0) chan_vals[0][7:0] = HEADER_BYTE;
          if ($urandom_range(9) == 0) stim_q.push_back(HEADER_BYTE);
          if ($urandom_range(9) == 0) build_frame(16'($urandom_range(65535, 1)));
          else build_frame(16'h0000);
          // Occasionally cut the frame short.
          if ($urandom_range(19) == 0) begin
            n = $urandom_range(FRAME_LEN - 2, 1);
            repeat (n) void'(stim_q.pop_back());
          end
        end else if (kind < 85) begin
          for (int i = 0; i < CH; i++) chan_vals[i] = 16'($urandom_range(65535, 0));
          build_frame(16'h0000);
        end else begin
          repeat ($urandom_range(6, 1)) stim_q.push_back(8'($urandom_range(255, 0)));
        end
        phase_bytes += stim_q.size();
        send_bytes();
      end
    end
    push = 1'b0;

    // Wait for every queued channel, then watch for stray output.
    while (pending_channels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/srfr_pkg.sv
rtl/srfr_front.sv
rtl/srfr_cmdq.sv
rtl/srfr_back.sv
rtl/servo_frame_receiver_unit.sv
tb/tb.sv
